@@ rtl/core/vkct_pkg.sv @@
// Shared types, codes and defaults of the versioned key-count table.
package vkct_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 32;
	localparam int CNT_W           = 32;
	localparam int OPS_W           = 16;
	localparam int TID_W           = 32;
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;

	localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

	// word index of the configuration registers (paddr[2])
	localparam logic CFG_IDX_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_UNLINK = 2'd1,
		REQ_QUERY  = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		RSP_OK    = 2'd0,
		RSP_EMPTY = 2'd1,
		RSP_FULL  = 2'd2
	} rsp_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY
	} fsm_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_full;
	} dp_stat_t;

endpackage

@@ rtl/core/vkct_if.sv @@
// Request and response channel interfaces of the key-count table.
interface vkct_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] trans_id;
	logic [15:0] op_count;
	logic        new_key;
	logic [31:0] next_id;

	modport source (output valid, req_type, trans_id, op_count, new_key, next_id,
		input ready);
	modport sink (input valid, req_type, trans_id, op_count, new_key, next_id,
		output ready);
endinterface

interface vkct_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] key_count;
	logic [1:0]         status;

	modport source (output valid, key_count, status, input ready);
	modport sink (input valid, key_count, status, output ready);
endinterface

@@ rtl/core/vkct_ctrl.sv @@
// Sequencer of the key-count table: accept, scan the table, apply, hand over.
module vkct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vkct_pkg::dp_stat_t stat,
	output vkct_pkg::dp_cmd_t  cmd
);
	import vkct_pkg::*;

	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_last) state_d = S_APPLY;
			end
			S_APPLY: begin
				if (!stat.out_full) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_SCAN: begin
				cmd.step = 1'b1;
			end
			S_APPLY: begin
				cmd.apply = !stat.out_full;
			end
			default: ;
		endcase
	end

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == S_SCAN)
		else $error("scan did not follow an accepted beat");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && stat.scan_last) |=> state_q == S_APPLY)
		else $error("last scan step did not lead to apply");
	a_apply_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> in_ready && !cmd.step)
		else $error("not idle after apply");

endmodule

@@ rtl/core/vkct_dp.sv @@
// Datapath: entry table, one-entry-per-cycle scan unit, parallel update, result register.
module vkct_dp #(
	parameter int TABLE_DEPTH = vkct_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS     = vkct_pkg::ID_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vkct_pkg::dp_cmd_t              cmd,
	output vkct_pkg::dp_stat_t             stat,
	input  logic [31:0]                    limit,
	input  logic [1:0]                     req_type,
	input  logic [vkct_pkg::TID_W-1:0]     trans_id,
	input  logic [vkct_pkg::OPS_W-1:0]     op_count,
	input  logic                           new_key,
	input  logic [vkct_pkg::TID_W-1:0]     next_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [vkct_pkg::CNT_W-1:0] key_count,
	output logic [1:0]                     status
);
	import vkct_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CMP_W = (ID_BITS > 32) ? ID_BITS : 32;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

	// entry table
	logic [ID_BITS-1:0]     ent_id_q  [TABLE_DEPTH];
	logic [CNT_W-1:0]       ent_cnt_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] ent_vld_q;

	// latched request
	logic [1:0]         req_q;
	logic [ID_BITS-1:0] tid_q;
	logic [ID_BITS-1:0] next_q;
	logic [OPS_W-1:0]   ops_q;
	logic               fresh_q;

	// scan results
	logic [IDX_W-1:0] idx_q;
	logic             any_q;
	logic             exact_q;
	logic [CNT_W-1:0] exact_cnt_q;
	logic             near_q;
	logic [CNT_W-1:0] near_cnt_q;
	logic [CMP_W-1:0] best_off_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// result register
	logic               out_vld_q;
	logic [CNT_W-1:0]   out_cnt_q;
	rsp_status_t        out_st_q;

	logic [ID_BITS-1:0] cur_id;
	logic [CNT_W-1:0]   cur_cnt;
	logic               cur_vld;
	logic [ID_BITS-1:0] cur_diff;
	logic [CMP_W-1:0]   cur_off;

	logic               is_ins, is_unl, is_qry;
	logic               ins_full, ins_ok, ins_new, unl_ok;
	logic [CNT_W-1:0]   ops_ext, seed, new_cnt, qry_cnt;
	rsp_status_t        st_d;

	assign cur_id   = ent_id_q[idx_q];
	assign cur_cnt  = ent_cnt_q[idx_q];
	assign cur_vld  = ent_vld_q[idx_q];
	assign cur_diff = tid_q - cur_id;
	assign cur_off  = CMP_W'(cur_diff);

	assign stat.scan_last = (idx_q == IDX_LAST);
	assign stat.out_full  = out_vld_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q   <= req_type;
			tid_q   <= ID_BITS'(trans_id);
			next_q  <= ID_BITS'(next_id);
			ops_q   <= op_count;
			fresh_q <= new_key;
		end
	end

	// scan: one entry per cycle, tracking exact hit, nearest lower and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			any_q   <= 1'b0;
			exact_q <= 1'b0;
			near_q  <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.start) begin
			idx_q   <= '0;
			any_q   <= 1'b0;
			exact_q <= 1'b0;
			near_q  <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			if (cur_vld) begin
				any_q <= 1'b1;
				if (cur_id == tid_q) exact_q <= 1'b1;
				if (cur_id < tid_q && cur_off < best_off_q) near_q <= 1'b1;
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_off_q <= CMP_W'(limit);
		end else if (cmd.step) begin
			if (cur_vld) begin
				if (cur_id == tid_q) exact_cnt_q <= cur_cnt;
				if (cur_id < tid_q && cur_off < best_off_q) begin
					best_off_q <= cur_off;
					near_cnt_q <= cur_cnt;
				end
			end else if (!free_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	// decisions taken from the scan
	assign is_ins   = (req_q == REQ_INSERT);
	assign is_unl   = (req_q == REQ_UNLINK);
	assign is_qry   = (req_q == REQ_QUERY);
	assign ins_full = is_ins && !exact_q && !free_q;
	assign ins_ok   = is_ins && !ins_full;
	assign ins_new  = ins_ok && !exact_q;
	assign unl_ok   = is_unl && any_q;
	assign ops_ext  = CNT_W'(ops_q);
	assign seed     = near_q ? near_cnt_q : '0;
	assign qry_cnt  = exact_q ? exact_cnt_q : seed;

	always_comb begin
		if (!any_q) begin
			new_cnt = ops_ext;
		end else if (fresh_q) begin
			new_cnt = seed + ops_ext;
		end else begin
			new_cnt = seed;
		end
	end

	always_comb begin
		if (ins_full) begin
			st_d = RSP_FULL;
		end else if (is_unl && !any_q) begin
			st_d = RSP_EMPTY;
		end else begin
			st_d = RSP_OK;
		end
	end

	// parallel update of every entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (cmd.apply && ins_new) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (free_idx_q == IDX_W'(i)) ent_vld_q[i] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (ins_new && free_idx_q == IDX_W'(i)) begin
					ent_id_q[i]  <= tid_q;
					ent_cnt_q[i] <= new_cnt;
				end else if (ent_vld_q[i]) begin
					if (ins_ok && any_q &&
						((ent_id_q[i] > tid_q && (fresh_q || ent_id_q[i] < next_q)) ||
						 (fresh_q && ent_id_q[i] == tid_q))) begin
						ent_cnt_q[i] <= ent_cnt_q[i] + ops_ext;
					end else if (unl_ok && ent_id_q[i] >= tid_q &&
						(next_q == '0 || ent_id_q[i] < next_q)) begin
						ent_cnt_q[i] <= ent_cnt_q[i] - 1'b1;
					end
				end
			end
		end
	end

	// result register; a new result may load in the cycle the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.apply) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			out_cnt_q <= is_qry ? qry_cnt : '0;
			out_st_q  <= st_d;
		end
	end

	assign out_valid = out_vld_q;
	assign key_count = $signed(out_cnt_q);
	assign status    = out_st_q;

	a_vld_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (ent_vld_q & $past(ent_vld_q)) == $past(ent_vld_q))
		else $error("table entry lost its valid bit");
	a_vld_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && ins_new) |=>
		$countones(ent_vld_q) == $past($countones(ent_vld_q)) + 1)
		else $error("new entry not added exactly once");
	a_full_real: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && st_d == RSP_FULL) |-> (&ent_vld_q))
		else $error("table full reported with a free slot");

endmodule

@@ rtl/core/versioned_key_count_table.sv @@
// Versioned key-count table.
// Requests arrive on req (valid/ready beat): insert, unlink or count query of a
// transaction id. Each request yields one response beat on rsp with key_count
// (query only, else 0) and status (ok, unlink on empty table, table full).
// Up to TABLE_DEPTH entries of (id, count) live in flops; ids are trans_id
// reduced to ID_BITS bits.
// Flow: a request is taken only while the block is idle. It then passes through
// the scan unit, which walks one entry per cycle looking for the exact id, the
// nearest lower id and the first free slot, and then applies the update to all
// entries at once. A new request is accepted only after the previous one has
// been applied.
// The response sits in an output register: a stalled receiver does not block
// the next request, which runs up to its apply step and waits there.
// Reset empties the table and sets nearest_limit (APB offset 0) to all ones.
module versioned_key_count_table #(
	parameter int TABLE_DEPTH = vkct_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS     = vkct_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vkct_req_if.sink                        req,
	vkct_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vkct_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [vkct_pkg::APB_DATA_W-1:0] pwdata,
	output logic [vkct_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import vkct_pkg::*;

	logic [31:0] limit_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic        in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_LIMIT) begin
			limit_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_LIMIT) ? limit_q : '0;

	assign req.ready = in_ready;

	vkct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vkct_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.limit     (limit_q),
		.req_type  (req.req_type),
		.trans_id  (req.trans_id),
		.op_count  (req.op_count),
		.new_key   (req.new_key),
		.next_id   (req.next_id),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.key_count (rsp.key_count),
		.status    (rsp.status)
	);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the versioned key-count table: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb_top;
	import vkct_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int ITEMS_PER_PHASE = 220;
	localparam int N_PHASES = 6;
	localparam int N_DIRECTED = 21;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {CFG_IDX_LIMIT, 2'b00};

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] tid;
		logic [15:0] ops;
		logic        fresh;
		logic [31:0] nxt;
		logic        typed;
		logic [31:0] cnt;
		logic [1:0]  st;
	} dir_row_t;

	typedef struct {
		logic [31:0] cnt;
		logic [1:0]  st;
	} count_rsp_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	vkct_req_if req_ch ();
	vkct_rsp_if rsp_ch ();

	versioned_key_count_table dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the table and its register
	logic [31:0] tbl_id [DEPTH];
	logic [31:0] tbl_cnt [DEPTH];
	bit          tbl_vld [DEPTH];
	logic [31:0] near_limit;

	count_rsp_t pending_rsp [$];
	int err_count = 0;
	int n_insert = 0, n_unlink = 0, n_query = 0, n_full = 0, n_empty = 0;
	int n_settings = 0;
	bit tx_quiet = 0;
	logic rx_quiet;
	int rx_hold;
	count_rsp_t rx_want;

	// columns: kind, tid, ops, new key, next id, typed, count, status
	dir_row_t dir_rows [N_DIRECTED] = '{
		'{REQ_QUERY,  32'd0,         16'd0,      1'b0, 32'd0,         1'b1, 32'd0,      RSP_OK},
		'{REQ_UNLINK, 32'd5,         16'd0,      1'b0, 32'd0,         1'b1, 32'd0,      RSP_EMPTY},
		'{REQ_INSERT, 32'd100,       16'hFFFF,   1'b1, 32'd0,         1'b1, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'd100,       16'd0,      1'b0, 32'd0,         1'b1, 32'hFFFF,   RSP_OK},
		// old key with nothing below seeds zero
		'{REQ_INSERT, 32'd50,        16'd7,      1'b0, 32'd100,       1'b1, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'd50,        16'd0,      1'b0, 32'd0,         1'b1, 32'd0,      RSP_OK},
		'{REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF,   1'b1, 32'd0,         1'b1, 32'd0,      RSP_OK},
		'{REQ_INSERT, 32'd0,         16'd3,      1'b0, 32'hFFFF_FFFF, 1'b0, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'd101,       16'd0,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_UNLINK, 32'd0,         16'd0,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_UNLINK, 32'd60,        16'd0,      1'b0, 32'd200,       1'b0, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'd0,         16'd0,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'hFFFF_FFFF, 16'd0,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_INSERT, 32'd100,       16'd9,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_INSERT, 32'd100,       16'd9,      1'b1, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_INSERT, 32'd75,        16'd0,      1'b1, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'd76,        16'd0,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF,   1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0,      RSP_OK},
		'{REQ_UNLINK, 32'hFFFF_FFFF, 16'd0,      1'b0, 32'hFFFF_FFFF, 1'b0, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'h8000_0000, 16'd0,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK},
		'{REQ_QUERY,  32'h7FFF_FFFF, 16'd0,      1'b0, 32'd0,         1'b0, 32'd0,      RSP_OK}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int exact_slot(logic [31:0] tid);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_vld[i] && tbl_id[i] == tid)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < DEPTH; i++)
			if (!tbl_vld[i])
				return i;
		return -1;
	endfunction

	// closest valid id strictly below tid, ignoring distances >= near_limit
	function automatic int nearest_below(logic [31:0] tid);
		logic [31:0] best_off;
		logic [31:0] off;
		int best;
		best_off = near_limit;
		best = -1;
		for (int i = 0; i < DEPTH; i++) begin
			if (tbl_vld[i] && tbl_id[i] < tid) begin
				off = tid - tbl_id[i];
				if (off < best_off) begin
					best_off = off;
					best = i;
				end
			end
		end
		return best;
	endfunction

	task automatic apply_request(input logic [1:0] kind, input logic [31:0] tid,
		input logic [15:0] ops, input logic fresh, input logic [31:0] nxt,
		output logic [31:0] cnt, output logic [1:0] st);
		int hit, slot, near;
		bit empty;
		logic [31:0] seed;
		cnt = '0;
		st = RSP_OK;
		empty = 1'b1;
		for (int i = 0; i < DEPTH; i++)
			if (tbl_vld[i])
				empty = 1'b0;
		case (kind)
			REQ_INSERT: begin
				n_insert++;
				hit = exact_slot(tid);
				slot = (hit < 0) ? free_slot() : -1;
				if (hit < 0 && slot < 0) begin
					st = RSP_FULL;
					n_full++;
				end else if (empty) begin
					tbl_id[slot] = tid;
					tbl_cnt[slot] = {16'd0, ops};
					tbl_vld[slot] = 1'b1;
				end else begin
					if (hit < 0) begin
						near = nearest_below(tid);
						seed = (near < 0) ? 32'd0 : tbl_cnt[near];
						tbl_id[slot] = tid;
						tbl_cnt[slot] = fresh ? seed + ops : seed;
					end else if (fresh) begin
						tbl_cnt[hit] = tbl_cnt[hit] + ops;
					end
					// new slot is not yet valid, so it is skipped here
					for (int i = 0; i < DEPTH; i++)
						if (tbl_vld[i] && tbl_id[i] > tid && (fresh || tbl_id[i] < nxt))
							tbl_cnt[i] = tbl_cnt[i] + ops;
					if (hit < 0)
						tbl_vld[slot] = 1'b1;
				end
			end
			REQ_UNLINK: begin
				n_unlink++;
				if (empty) begin
					st = RSP_EMPTY;
					n_empty++;
				end else begin
					for (int i = 0; i < DEPTH; i++)
						if (tbl_vld[i] && tbl_id[i] >= tid && (nxt == 0 || tbl_id[i] < nxt))
							tbl_cnt[i] = tbl_cnt[i] - 1;
				end
			end
			REQ_QUERY: begin
				n_query++;
				hit = exact_slot(tid);
				if (hit < 0)
					hit = nearest_below(tid);
				cnt = (hit < 0) ? 32'd0 : tbl_cnt[hit];
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// one beat on req; gap drawn per beat, prediction taken at the accepting edge
	task automatic send_req(input logic [1:0] kind, input logic [31:0] tid,
		input logic [15:0] ops, input logic fresh, input logic [31:0] nxt,
		input logic typed, input logic [31:0] t_cnt, input logic [1:0] t_st);
		int gap;
		logic [31:0] p_cnt;
		logic [1:0] p_st;
		count_rsp_t beat;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.trans_id <= tid;
		req_ch.op_count <= ops;
		req_ch.new_key  <= fresh;
		req_ch.next_id  <= nxt;
		do @(posedge clk); while (!req_ch.ready);
		apply_request(kind, tid, ops, fresh, nxt, p_cnt, p_st);
		beat.cnt = typed ? t_cnt : p_cnt;
		beat.st = typed ? t_st : p_st;
		pending_rsp.push_back(beat);
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= LIMIT_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// half the time ids at or near what is already stored, so nearest-lower and ranges get exercised
	function automatic logic [31:0] pick_tid();
		int live [$];
		int pick;
		pick = $urandom_range(0, 9);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_vld[i])
				live.push_back(i);
		case (pick)
			0, 1, 2, 3, 4: begin
				if (live.size() == 0)
					return $urandom_range(0, 5000);
				if ($urandom_range(0, 3) == 0)
					return tbl_id[live[$urandom_range(0, live.size() - 1)]]
						+ $urandom_range(0, 4) - 32'd2;
				return tbl_id[live[$urandom_range(0, live.size() - 1)]];
			end
			5, 6, 7: return $urandom_range(0, 5000);
			8: return $urandom();
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	task automatic rand_item();
		int r;
		logic [1:0] kind;
		logic [15:0] ops;
		logic [31:0] nxt;
		r = $urandom_range(0, 19);
		kind = (r < 7) ? REQ_INSERT : (r < 11) ? REQ_UNLINK : (r < 19) ? REQ_QUERY : REQ_UNUSED;
		case ($urandom_range(0, 7))
			0: ops = 16'd0;
			1: ops = 16'hFFFF;
			default: ops = 16'($urandom_range(0, 65535));
		endcase
		nxt = ($urandom_range(0, 3) == 0) ? 32'd0 : pick_tid();
		send_req(kind, pick_tid(), ops, 1'($urandom_range(0, 1)), nxt, 1'b0, 32'd0, RSP_OK);
	endtask

	// receiver: per beat draws how long ready stays low afterwards
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("response with nothing pending", rsp_ch.key_count, 32'd0);
			end else begin
				rx_want = pending_rsp.pop_front();
				if (rsp_ch.key_count !== rx_want.cnt)
					report_mismatch("key_count", rsp_ch.key_count, rx_want.cnt);
				if (rsp_ch.status !== rx_want.st)
					report_mismatch("status", 32'(rsp_ch.status), 32'(rx_want.st));
			end
			rx_hold = rx_quiet ? 0 : $urandom_range(0, 5);
			rsp_ch.ready <= (rx_hold == 0);
		end else if (rx_hold > 1) begin
			rx_hold = rx_hold - 1;
		end else begin
			rx_hold = 0;
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		logic [31:0] limit_plan [N_PHASES];
		logic [31:0] rd;
		dir_row_t row;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.trans_id = '0;
		req_ch.op_count = '0;
		req_ch.new_key = 1'b0;
		req_ch.next_id = '0;
		rsp_ch.ready = 1'b0;
		rx_quiet = 1'b0;
		rx_hold = 0;
		near_limit = LIMIT_RESET;
		for (int i = 0; i < DEPTH; i++)
			tbl_vld[i] = 1'b0;
		limit_plan = '{LIMIT_RESET, 32'd0, 32'd1, 32'd3000, $urandom(), 32'hFFFF_FFFF};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIRECTED; k++) begin
			row = dir_rows[k];
			send_req(row.kind, row.tid, row.ops, row.fresh, row.nxt, row.typed, row.cnt, row.st);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			hold_until_drained();
			repeat (DEPTH + 4) @(posedge clk);
			if (ph > 0) begin
				apb_access(1'b1, limit_plan[ph], rd);
				near_limit = limit_plan[ph];
				@(posedge clk);
			end
			apb_access(1'b0, 32'd0, rd);
			if (rd !== near_limit)
				report_mismatch("nearest_limit readback", rd, near_limit);
			n_settings++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == 100)
					hold_until_drained();
				tx_quiet = (n >= 150 && n < 190);
				rx_quiet <= tx_quiet;
				rand_item();
			end
			tx_quiet = 1'b0;
			rx_quiet <= 1'b0;
		end

		hold_until_drained();
		repeat (DEPTH + 8) @(posedge clk);
		$display("Covered %0d inserts (%0d full), %0d unlinks (%0d on empty), %0d queries",
			n_insert, n_full, n_unlink, n_empty, n_query);
		$display("Ran under %0d nearest_limit settings, zero and all ones among them; %0d mismatches",
			n_settings, err_count);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/vkct_pkg.sv
rtl/core/vkct_if.sv
rtl/core/vkct_ctrl.sv
rtl/core/vkct_dp.sv
rtl/core/versioned_key_count_table.sv
tb/tb_top.sv
